[rtl/stt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Software timer table package
// Sizes, the entry record, command and status codes and controller states.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  localparam int CMD_W    = 3;
  localparam int STATUS_W = 3;
  localparam int ID_W     = 16;
  localparam int DELAY_W  = 32;
  localparam int TIME_W   = 48;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  due;
    logic [DELAY_W-1:0] period;
    logic               periodic;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [CMD_W-1:0] {
    CMD_SCHED_ONCE     = 3'd0,
    CMD_SCHED_PERIODIC = 3'd1,
    CMD_REMOVE         = 3'd2,
    CMD_TICK           = 3'd3,
    CMD_CLEAR          = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_SCHEDULED = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_REMOVED   = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_FIRED     = 3'd4,
    STAT_TICK_DONE = 3'd5,
    STAT_CLEARED   = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCHED,
    S_CLEAR,
    S_SCAN,
    S_FINISH
  } state_e;

endpackage

[rtl/stt_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                         wr_data_i,
  input  logic                                     rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // The read data holds while the read enable is low.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/software_timer_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Software timer table
// Keeps up to MAX_TASKS one-shot and periodic timers in insertion order in a
// single entry RAM and reports scheduling, removal and firing results.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid_i/in_stall_o | cmd_i, delay_i, target_id_i, now_i
//  output  | out_valid_o/out_stall_i | status_o, task_id_o, last_o
//
// A schedule or clear transaction goes through S_SCHED or S_CLEAR, which loads
// its report into the output register once that register can take it, and the
// input is free again after that. A remove or a tick walks the table once, one
// entry per cycle through the RAM read port while no report holds it, and then
// loads its final result in S_FINISH; the input is free again after that. Reset
// needs no clearing pass: the table is empty after reset and unwritten entries
// are never read. A stalled output register holds the walk at the entry that
// wants to report, and new transactions wait until the current one is done.
//
// The table is compacted in place while it is walked: each kept entry is
// written back at the write index, which never passes the read index, so a
// read and a write in the same cycle always touch different entries. Removed
// entries and fired one-shot entries are simply not written back, which
// closes the gap they leave. At the end of the walk the write index is the
// new entry count.
// ----------------------------------------------------------------------------
module software_timer_table import stt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [DELAY_W-1:0]  delay_i,
  input  logic [ID_W-1:0]     target_id_i,
  input  logic [TIME_W-1:0]   now_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [ID_W-1:0]     task_id_o,
  output logic                last_o
);

  // Controller state and table bookkeeping.
  state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [ID_W-1:0]  next_id_q, next_id_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0] wr_idx_q, wr_idx_d;
  logic             ev_q, ev_d;
  logic             found_q, found_d;

  // Latched transaction fields.
  logic [CMD_W-1:0]   cmd_q, cmd_d;
  logic [DELAY_W-1:0] delay_q, delay_d;
  logic [ID_W-1:0]    target_q, target_d;
  logic [TIME_W-1:0]  now_q, now_d;

  // Output register.
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [ID_W-1:0]     task_id_q, task_id_d;
  logic                last_q, last_d;

  // RAM ports.
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic    accept;
  logic    out_ld_ok;
  logic    is_tick;
  logic    is_full;
  entry_t  cur;
  logic    is_due;
  logic    id_match;
  logic    need_emit;
  logic    advance;
  logic    scan_done;
  logic    emit;
  status_e emit_status;
  logic [ID_W-1:0] emit_id;
  logic    emit_last;

  stt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TASKS)
  ) u_entry_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  // The output register can take a new result when it is empty or drains now.
  assign out_ld_ok  = !out_valid_q || !out_stall_i;

  assign is_tick  = (cmd_q == CMD_TICK);
  assign is_full  = (count_q == CNT_W'(MAX_TASKS));
  assign cur      = entry_t'(ram_rdata);
  assign is_due   = (now_q >= cur.due);
  assign id_match = !found_q && (cur.id == target_q);

  // Only a due entry during a tick produces a result mid-walk, so it is the
  // only case that can hold the walk back.
  assign need_emit = ev_q && is_tick && is_due;
  assign advance   = !need_emit || out_ld_ok;
  assign scan_done = !ev_q && (rd_idx_q == count_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority case (cmd_i)
            CMD_SCHED_ONCE,
            CMD_SCHED_PERIODIC: state_d = S_SCHED;
            CMD_REMOVE,
            CMD_TICK:           state_d = S_SCAN;
            CMD_CLEAR:          state_d = S_CLEAR;
            default:            state_d = S_IDLE;
          endcase
        end
      end
      S_SCHED, S_CLEAR, S_FINISH: begin
        if (out_ld_ok) begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_d = S_FINISH;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    count_d     = count_q;
    next_id_d   = next_id_q;
    rd_idx_d    = rd_idx_q;
    wr_idx_d    = wr_idx_q;
    ev_d        = ev_q;
    found_d     = found_q;
    cmd_d       = cmd_q;
    delay_d     = delay_q;
    target_d    = target_q;
    now_d       = now_q;
    ram_we      = 1'b0;
    ram_waddr   = wr_idx_q[IDX_W-1:0];
    ram_wdata   = cur;
    ram_re      = 1'b0;
    ram_raddr   = rd_idx_q[IDX_W-1:0];
    emit        = 1'b0;
    emit_status = STAT_TICK_DONE;
    emit_id     = '0;
    emit_last   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d    = cmd_i;
          delay_d  = delay_i;
          target_d = target_id_i;
          now_d    = now_i;
          rd_idx_d = '0;
          wr_idx_d = '0;
          ev_d     = 1'b0;
          found_d  = 1'b0;
        end
      end

      S_SCHED: begin
        if (out_ld_ok) begin
          emit = 1'b1;
          if (is_full) begin
            emit_status = STAT_FULL;
          end else begin
            ram_we             = 1'b1;
            ram_waddr          = count_q[IDX_W-1:0];
            ram_wdata.id       = next_id_q;
            ram_wdata.due      = now_q + TIME_W'(delay_q);
            ram_wdata.period   = delay_q;
            ram_wdata.periodic = (cmd_q == CMD_SCHED_PERIODIC);
            emit_status        = STAT_SCHEDULED;
            emit_id            = next_id_q;
            count_d            = count_q + CNT_W'(1);
            next_id_d          = next_id_q + ID_W'(1);
          end
        end
      end

      S_CLEAR: begin
        if (out_ld_ok) begin
          emit        = 1'b1;
          emit_status = STAT_CLEARED;
          count_d     = '0;
          next_id_d   = '0;
        end
      end

      S_SCAN: begin
        // Evaluate the entry whose read data is present.
        if (ev_q && advance) begin
          if (is_tick) begin
            if (is_due) begin
              emit        = 1'b1;
              emit_status = STAT_FIRED;
              emit_id     = cur.id;
              emit_last   = 1'b0;
              if (cur.periodic) begin
                ram_we        = 1'b1;
                ram_wdata.due = now_q + TIME_W'(cur.period);
                wr_idx_d      = wr_idx_q + CNT_W'(1);
              end
            end else begin
              ram_we   = 1'b1;
              wr_idx_d = wr_idx_q + CNT_W'(1);
            end
          end else begin
            if (id_match) begin
              found_d = 1'b1;
            end else begin
              ram_we   = 1'b1;
              wr_idx_d = wr_idx_q + CNT_W'(1);
            end
          end
        end
        // Fetch the next entry while the current one retires.
        if (advance) begin
          if (rd_idx_q < count_q) begin
            ram_re   = 1'b1;
            rd_idx_d = rd_idx_q + CNT_W'(1);
            ev_d     = 1'b1;
          end else begin
            ev_d = 1'b0;
          end
        end
      end

      S_FINISH: begin
        if (out_ld_ok) begin
          emit    = 1'b1;
          count_d = wr_idx_q;
          if (is_tick) begin
            emit_status = STAT_TICK_DONE;
          end else begin
            emit_status = found_q ? STAT_REMOVED : STAT_NOT_FOUND;
            emit_id     = target_q;
          end
        end
      end

      default: begin
      end
    endcase

    // Output register load and drain.
    out_valid_d = out_valid_q;
    status_d    = status_q;
    task_id_d   = task_id_q;
    last_d      = last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      status_d    = emit_status;
      task_id_d   = emit_id;
      last_d      = emit_last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      next_id_q   <= '0;
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      ev_q        <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      next_id_q   <= next_id_d;
      rd_idx_q    <= rd_idx_d;
      wr_idx_q    <= wr_idx_d;
      ev_q        <= ev_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    delay_q   <= delay_d;
    target_q  <= target_d;
    now_q     <= now_d;
    status_q  <= status_d;
    task_id_q <= task_id_d;
    last_q    <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign task_id_o   = task_id_q;
  assign last_o      = last_q;

endmodule

[tb/software_timer_table_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Software timer table testbench
// Drives schedule, remove, tick and clear transactions into the timer table,
// predicts every status report from its own copy of the table and checks each
// report from the block field by field, in order.
// ----------------------------------------------------------------------------
module software_timer_table_test;
  import stt_pkg::*;

  // Cycles the receiver holds off in the backpressure test. This is far more
  // than the block needs to fill its output register and stall its input.
  localparam int LONG_HOLD_CYCLES = 300;
  // Quiet cycles after the last expected report. They let an ignored command
  // finish and let any stray report show up.
  localparam int SETTLE_CYCLES = 40;
  // Commands above the clear code are not decoded by the block.
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
  localparam logic [CMD_W-1:0] CMD_LAST_UNUSED  = 3'd7;

  // One status report as the block sends it.
  typedef struct packed {
    status_e         status;
    logic [ID_W-1:0] task_id;
    logic            last;
  } report_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [CMD_W-1:0]    cmd_i;
  logic [DELAY_W-1:0]  delay_i;
  logic [ID_W-1:0]     target_id_i;
  logic [TIME_W-1:0]   now_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [STATUS_W-1:0] status_o;
  logic [ID_W-1:0]     task_id_o;
  logic                last_o;

  software_timer_table DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .delay_i     (delay_i),
    .target_id_i (target_id_i),
    .now_i       (now_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .task_id_o   (task_id_o),
    .last_o      (last_o)
  );

  // --------------------------------------------------------------------------
  // Predicted timer table. It mirrors the state of the block: the entries in
  // insertion order, how many are valid, and the next id to hand out.
  // --------------------------------------------------------------------------
  logic [ID_W-1:0]    tbl_id       [MAX_TASKS];
  logic [TIME_W-1:0]  tbl_due      [MAX_TASKS];
  logic [DELAY_W-1:0] tbl_period   [MAX_TASKS];
  logic               tbl_periodic [MAX_TASKS];
  int                 tbl_count;
  logic [ID_W-1:0]    id_next;

  // Reports still owed by the block, oldest first.
  report_t expected_reports[$];
  int      mismatch_count;

  // Run controls shared by the stimulus and the receiver.
  bit idle_en;
  bit long_hold_req;
  int stall_left;
  logic [TIME_W-1:0] clock_ms;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic void owe_report(status_e status, logic [ID_W-1:0] id, logic last);
    report_t r;
    r.status  = status;
    r.task_id = id;
    r.last    = last;
    expected_reports.insert(expected_reports.size(), r);
  endfunction

  // Closing the gap keeps the entries in insertion order.
  function automatic void drop_slot(int pos);
    for (int i = pos; i + 1 < tbl_count; i++) begin
      tbl_id[i]       = tbl_id[i + 1];
      tbl_due[i]      = tbl_due[i + 1];
      tbl_period[i]   = tbl_period[i + 1];
      tbl_periodic[i] = tbl_periodic[i + 1];
    end
    tbl_count--;
  endfunction

  // Applies one accepted transaction to the predicted table and queues the
  // reports that it must produce.
  function automatic void predict_reports(logic [CMD_W-1:0] cmd, logic [DELAY_W-1:0] delay,
                                          logic [ID_W-1:0] target, logic [TIME_W-1:0] now);
    int  i;
    bit  found;
    case (cmd)
      CMD_SCHED_ONCE, CMD_SCHED_PERIODIC: begin
        if (tbl_count == MAX_TASKS) begin
          // A full table stores nothing and uses up no id.
          owe_report(STAT_FULL, '0, 1'b1);
        end else begin
          tbl_id[tbl_count]       = id_next;
          tbl_due[tbl_count]      = now + TIME_W'(delay);
          tbl_period[tbl_count]   = delay;
          tbl_periodic[tbl_count] = (cmd == CMD_SCHED_PERIODIC);
          tbl_count++;
          owe_report(STAT_SCHEDULED, id_next, 1'b1);
          id_next++;
        end
      end
      CMD_REMOVE: begin
        found = 1'b0;
        // Only the first entry with a matching id goes, even when ids repeat.
        for (i = 0; i < tbl_count && !found; i++) begin
          if (tbl_id[i] == target) begin
            drop_slot(i);
            found = 1'b1;
          end
        end
        owe_report(found ? STAT_REMOVED : STAT_NOT_FOUND, target, 1'b1);
      end
      CMD_TICK: begin
        i = 0;
        while (i < tbl_count) begin
          if (now >= tbl_due[i]) begin
            owe_report(STAT_FIRED, tbl_id[i], 1'b0);
            if (tbl_periodic[i]) begin
              tbl_due[i] = now + TIME_W'(tbl_period[i]);
              i++;
            end else begin
              drop_slot(i);
            end
          end else begin
            i++;
          end
        end
        owe_report(STAT_TICK_DONE, '0, 1'b1);
      end
      CMD_CLEAR: begin
        tbl_count = 0;
        id_next   = '0;
        owe_report(STAT_CLEARED, '0, 1'b1);
      end
      default: begin
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Inputs change on the falling edge. A transaction is taken at the
  // first rising edge with the stall low, and only then does it reach the
  // predictor. While idling is enabled a random gap may come before the item,
  // with valid low during the gap.
  // --------------------------------------------------------------------------
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [DELAY_W-1:0] delay,
                           logic [ID_W-1:0] target, logic [TIME_W-1:0] now);
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    delay_i     <= delay;
    target_id_i <= target;
    now_i       <= now;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    predict_reports(cmd, delay, target, now);
  endtask

  // Parks the sender with valid low until the block has sent every report.
  task automatic wait_for_reports();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [TIME_W-1:0] random_time();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // --------------------------------------------------------------------------
  // Receiver. The stall changes on the falling edge. It stalls in random
  // bursts while idling is enabled, and once for a long stretch on request.
  // --------------------------------------------------------------------------
  initial begin
    out_stall_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LONG_HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        stall_left  = $urandom_range(0, 6);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Each report taken from the block is matched against the oldest expected
  // one. A report with nothing expected is a failure of its own.
  always @(posedge clk_i) begin
    report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected report: status %0d task_id %0d last %0d",
               status_o, task_id_o, last_o);
        mismatch_count++;
      end else begin
        want = expected_reports.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          mismatch_count++;
        end
        if (task_id_o !== want.task_id) begin
          $error("task_id: expected %0d, actual %0d", want.task_id, task_id_o);
          mismatch_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, last_o);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed cases: an empty table, time and delay at their extremes, due
  // times that wrap past the top of the time range, the ignored command
  // codes, a full table, and a tick that fires every entry at once.
  // --------------------------------------------------------------------------
  task automatic test_directed_extremes();
    send_item(CMD_TICK, '0, '0, '0);
    send_item(CMD_REMOVE, '0, '1, '0);
    send_item(CMD_SCHED_ONCE, '0, '0, '0);
    // The due time of this one wraps to just below 2^32.
    send_item(CMD_SCHED_PERIODIC, '1, '0, '1);
    send_item(CMD_TICK, '0, '0, '0);
    send_item(CMD_TICK, '0, '0, '1);
    for (logic [CMD_W-1:0] c = CMD_FIRST_UNUSED; c <= CMD_LAST_UNUSED; c++) begin
      send_item(c, '1, '1, '1);
      if (c == CMD_LAST_UNUSED) break;
    end
    // One periodic entry is left, so fifteen more fill the table.
    for (int k = 0; k < MAX_TASKS - 1; k++)
      send_item(k[0] ? CMD_SCHED_PERIODIC : CMD_SCHED_ONCE,
                k[1] ? '1 : DELAY_W'($urandom_range(0, 3)), '0, random_time());
    send_item(CMD_SCHED_ONCE, '0, '0, '0);
    // Every entry is due at the top of the time range: the longest report.
    send_item(CMD_TICK, '0, '0, '1);
    send_item(CMD_REMOVE, '0, ID_W'(1), '0);
    send_item(CMD_CLEAR, '0, '0, '0);
  endtask

  // --------------------------------------------------------------------------
  // Backpressure: the receiver holds off for a long stretch while the sender
  // keeps offering work, so the block fills up and stalls its input. Then the
  // sender waits until every report is in before it goes on.
  // --------------------------------------------------------------------------
  task automatic test_backpressure();
    long_hold_req = 1'b1;
    for (int k = 0; k < 24; k++) begin
      if (k % 3 == 2) begin
        clock_ms += TIME_W'($urandom_range(0, 15));
        send_item(CMD_TICK, '0, '0, clock_ms);
      end else begin
        send_item($urandom_range(0, 1) ? CMD_SCHED_PERIODIC : CMD_SCHED_ONCE,
                  DELAY_W'($urandom_range(0, 20)), '0, clock_ms);
      end
    end
    wait_for_reports();
    clock_ms += 48'd100;
    send_item(CMD_TICK, '0, '0, clock_ms);
    send_item(CMD_REMOVE, '0, ID_W'($urandom_range(0, 20)), '0);
    send_item(CMD_CLEAR, '0, '0, '0);
  endtask

  // --------------------------------------------------------------------------
  // Random traffic. Most transactions follow a running clock so that entries
  // really come due, are re-armed and are removed by live ids. The clock
  // starts just below the top of the time range, so due times wrap early on.
  // The rest is noise: full range fields and the ignored command codes.
  // --------------------------------------------------------------------------
  task automatic test_random_traffic(int count);
    int n;
    int pick;
    n = 0;
    clock_ms = 48'hFFFF_FFFF_FF00;
    while (n < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_item($urandom_range(0, 1) ? CMD_SCHED_PERIODIC : CMD_SCHED_ONCE,
                  DELAY_W'($urandom_range(0, 40)), 16'($urandom), clock_ms);
      end else if (pick < 62) begin
        clock_ms += TIME_W'($urandom_range(0, 30));
        send_item(CMD_TICK, 32'($urandom), 16'($urandom), clock_ms);
      end else if (pick < 77) begin
        if (tbl_count > 0 && $urandom_range(0, 3) != 0)
          send_item(CMD_REMOVE, 32'($urandom), tbl_id[$urandom_range(0, tbl_count - 1)],
                    clock_ms);
        else
          send_item(CMD_REMOVE, 32'($urandom), 16'($urandom), random_time());
      end else if (pick < 80) begin
        send_item(CMD_CLEAR, 32'($urandom), 16'($urandom), random_time());
      end else if (pick < 88) begin
        // Ignored by the block, so it does not count toward the total.
        send_item(CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED)),
                  32'($urandom), 16'($urandom), random_time());
        continue;
      end else begin
        send_item(CMD_W'($urandom_range(CMD_SCHED_ONCE, CMD_CLEAR)),
                  32'($urandom), 16'($urandom), random_time());
      end
      n++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Closing burst. The table is filled to the top and one more schedule is
  // refused, an id is removed twice so the second remove finds nothing, and
  // two ticks fire part of the table and then all of it. This runs without
  // idling and closes the run.
  // --------------------------------------------------------------------------
  task automatic test_closing_burst();
    send_item(CMD_CLEAR, '0, '0, '0);
    for (int k = 0; k < MAX_TASKS; k++)
      send_item(k[0] ? CMD_SCHED_PERIODIC : CMD_SCHED_ONCE, DELAY_W'(k), '0, 48'd10);
    send_item(CMD_SCHED_ONCE, '0, '0, 48'd10);
    send_item(CMD_REMOVE, '0, ID_W'(3), '0);
    send_item(CMD_REMOVE, '0, ID_W'(3), '0);
    send_item(CMD_TICK, '0, '0, 48'd18);
    send_item(CMD_TICK, '0, '0, 48'd100);
    send_item(CMD_CLEAR, '0, '0, '0);
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    cmd_i          = CMD_SCHED_ONCE;
    delay_i        = '0;
    target_id_i    = '0;
    now_i          = '0;
    tbl_count      = 0;
    id_next        = '0;
    mismatch_count = 0;
    idle_en        = 1'b1;
    long_hold_req  = 1'b0;
    clock_ms       = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_extremes();
    test_backpressure();
    test_random_traffic(140);
    idle_en = 1'b0;
    test_closing_burst();

    wait_for_reports();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Even with every tick firing a full table under the longest stalls, the
  // whole run finishes well before this limit gives up.
  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[sim.f]
rtl/stt_pkg.sv
rtl/stt_ram.sv
rtl/software_timer_table.sv
tb/software_timer_table_test.sv
